@@ hdl/iac_pkg.sv @@
package iac_pkg;

   // Why an alert stopped in the current tick.
   typedef enum logic [1:0] {
      STOP_NONE    = 2'd0,
      STOP_RESET   = 2'd1,
      STOP_TIMEOUT = 2'd2
   } stop_type;

   // Configuration register indexes.
   localparam logic [2:0] CSR_ACCEL_LIMIT_SQ = 3'd0;
   localparam logic [2:0] CSR_GYRO_LIMIT_SQ  = 3'd1;
   localparam logic [2:0] CSR_ALARM_TICKS    = 3'd2;
   localparam logic [2:0] CSR_BLINK_TICKS    = 3'd3;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 33;
   localparam int LIMIT_W     = 33;
   localparam int TICK_W      = 32;
   localparam int SQ_W        = 31;
   localparam int SUM_W       = 32;

   // Reset values: 4 g at 16384 LSB/g and 250 dps at 131 LSB/dps, squared.
   localparam logic [LIMIT_W-1:0] ACCEL_LIMIT_SQ_RST = 33'd4294967296;
   localparam logic [LIMIT_W-1:0] GYRO_LIMIT_SQ_RST  = 33'd1072562500;
   localparam logic [TICK_W-1:0]  ALARM_TICKS_RST    = 32'd15000;
   localparam logic [TICK_W-1:0]  BLINK_TICKS_RST    = 32'd500;

   typedef struct packed {
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic signed [15:0] gyro_x;
      logic signed [15:0] gyro_y;
      logic signed [15:0] gyro_z;
      logic               panic_pressed;
      logic               reset_pressed;
   } req_type;

   typedef struct packed {
      logic     alarm_on;
      logic     alert_active;
      logic     panic_fired;
      logic     impact_fired;
      stop_type stop_reason;
   } rsp_type;

   // Summary of one sample after the magnitude check.
   typedef struct packed {
      logic panic;
      logic rst;
      logic accel_over;
      logic gyro_over;
   } mag_type;

endpackage

@@ hdl/impact_alarm_controller_core.sv @@
// Impact and panic alarm controller. One input transfer is one millisecond tick
// carrying a raw accelerometer and gyro sample plus the panic and reset button
// levels; every input transfer produces exactly one result transfer.
// Input channel req_*: a transfer happens at a clock edge with req_valid high and
// req_stall low. Result channel rsp_*: a transfer happens with rsp_valid high and
// rsp_stall low. Configuration port csr_*: csr_ready is always high, so a write
// lands at every edge with csr_valid high; write only while no tick is in flight.
// Ticks pass the input register, squaring stage, sum-and-compare stage, then the
// alarm state update that loads the result register. Throughput is one tick per
// cycle unless stalled; the alarm state (timers, active and blink flags) is read
// and written in the same cycle so back-to-back ticks see each other's effects.
// When the receiver stalls with a result waiting, the whole pipeline freezes and
// req_stall follows, so nothing is dropped and each result holds its value.
// Synchronous reset clears the pipeline valid bits, the tick counter, the alarm
// state and loads the configuration registers with their default thresholds
// (4 g, 250 dps), a 15000-tick alarm duration and a 500-tick blink interval.
module impact_alarm_controller_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  iac_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output iac_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [iac_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [iac_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import iac_pkg::*;

   // Configuration registers.
   logic [LIMIT_W-1:0] accel_limit_ff;
   logic [LIMIT_W-1:0] gyro_limit_ff;
   logic [TICK_W-1:0]  alarm_ticks_ff;
   logic [TICK_W-1:0]  blink_ticks_ff;

   // The pipeline moves as one unless a finished result is being held back.
   logic    advance;
   logic    in_valid_ff;
   req_type in_data_ff;
   logic    mag_valid;
   mag_type mag;

   // Alarm state.
   logic [TICK_W-1:0] tick_now_ff;
   logic [TICK_W-1:0] alert_start_ff;
   logic [TICK_W-1:0] alert_start_in;
   logic [TICK_W-1:0] last_toggle_ff;
   logic [TICK_W-1:0] last_toggle_in;
   logic              active_ff;
   logic              active_in;
   logic              blink_ff;
   logic              blink_in;
   logic              drive_ff;
   logic              drive_in;

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_limit_ff <= ACCEL_LIMIT_SQ_RST;
         gyro_limit_ff  <= GYRO_LIMIT_SQ_RST;
         alarm_ticks_ff <= ALARM_TICKS_RST;
         blink_ticks_ff <= BLINK_TICKS_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ACCEL_LIMIT_SQ: accel_limit_ff <= csr_wdata;
            CSR_GYRO_LIMIT_SQ:  gyro_limit_ff  <= csr_wdata;
            CSR_ALARM_TICKS:    alarm_ticks_ff <= csr_wdata[TICK_W-1:0];
            CSR_BLINK_TICKS:    blink_ticks_ff <= csr_wdata[TICK_W-1:0];
            default: begin
               // Indexes past the register list are dropped.
            end
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_data_ff <= req_data;
      end
   end

   iac_mag u_mag (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .in_valid       (in_valid_ff),
      .in_data        (in_data_ff),
      .accel_limit_sq (accel_limit_ff),
      .gyro_limit_sq  (gyro_limit_ff),
      .out_valid      (mag_valid),
      .out_data       (mag)
   );

   // One tick of the alarm sequence: panic raise, reset stop, then either the
   // magnitude check when idle or the timeout and blink handling when active.
   always_comb begin
      logic panic_fire;
      logic active_a;
      logic reset_stop;
      panic_fire     = mag.panic && !active_ff;
      active_a       = active_ff || mag.panic;
      reset_stop     = mag.rst && active_a;
      active_in      = active_a && !mag.rst;
      alert_start_in = panic_fire ? tick_now_ff : alert_start_ff;
      last_toggle_in = last_toggle_ff;
      blink_in       = blink_ff;
      drive_in       = reset_stop ? 1'b0 : drive_ff;
      rsp_data_in.panic_fired  = panic_fire;
      rsp_data_in.impact_fired = 1'b0;
      rsp_data_in.stop_reason  = reset_stop ? STOP_RESET : STOP_NONE;
      if (!active_in) begin
         if (mag.accel_over || mag.gyro_over) begin
            active_in                = 1'b1;
            alert_start_in           = tick_now_ff;
            rsp_data_in.impact_fired = 1'b1;
         end
      end else if (TICK_W'(tick_now_ff - alert_start_in) >= alarm_ticks_ff) begin
         active_in               = 1'b0;
         drive_in                = 1'b0;
         rsp_data_in.stop_reason = STOP_TIMEOUT;
      end else if (TICK_W'(tick_now_ff - last_toggle_ff) >= blink_ticks_ff) begin
         last_toggle_in = tick_now_ff;
         blink_in       = !blink_ff;
         drive_in       = !blink_ff;
      end
      rsp_data_in.alarm_on     = drive_in;
      rsp_data_in.alert_active = active_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_now_ff    <= '0;
         alert_start_ff <= '0;
         last_toggle_ff <= '0;
         active_ff      <= 1'b0;
         blink_ff       <= 1'b0;
         drive_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= mag_valid;
         if (mag_valid) begin
            tick_now_ff    <= tick_now_ff + 1'b1;
            alert_start_ff <= alert_start_in;
            last_toggle_ff <= last_toggle_in;
            active_ff      <= active_in;
            blink_ff       <= blink_in;
            drive_ff       <= drive_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   // The drive is cleared on every stop, so it can only be high during an alert.
   a_drive_needs_alert: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_data.alarm_on || rsp_data.alert_active))
      else $error("alarm_on high without an active alert");

   // A timeout ends the tick idle; no new alert can start after it.
   a_timeout_ends_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.stop_reason == STOP_TIMEOUT) |->
      (!rsp_data.alert_active && !rsp_data.alarm_on))
      else $error("alert still active after a timeout stop");

   // An impact raise is the last step of a tick, so the alert is still on.
   a_impact_leaves_active: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.impact_fired) |-> rsp_data.alert_active)
      else $error("impact fired but alert not active");

   // The alarm state only moves when a tick leaves the compare stage.
   a_tick_counts_items: assert property (@(posedge clock) disable iff (reset)
      !(mag_valid && advance) |=> $stable(tick_now_ff))
      else $error("tick counter moved without a tick");
`endif

endmodule

@@ hdl/iac_mag.sv @@
module iac_mag (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic                            in_valid,
   input  iac_pkg::req_type                in_data,
   input  logic [iac_pkg::LIMIT_W-1:0]     accel_limit_sq,
   input  logic [iac_pkg::LIMIT_W-1:0]     gyro_limit_sq,
   output logic                            out_valid,
   output iac_pkg::mag_type                out_data
);
   import iac_pkg::*;

   // Stage one: six squares. Stage two: two sums and the threshold compares.
   logic [SQ_W-1:0]  sq_ff [6];
   logic [SQ_W-1:0]  sq_in [6];
   logic             sq_valid_ff;
   logic             sq_panic_ff;
   logic             sq_rst_ff;
   logic [SUM_W-1:0] accel_sum;
   logic [SUM_W-1:0] gyro_sum;
   logic             mag_valid_ff;
   mag_type          mag_ff;
   mag_type          mag_in;

   // Each axis is sign extended to 32 bits before the multiply, so the full
   // square is kept even for the most negative sample.
   always_comb begin
      sq_in[0] = SQ_W'(32'(in_data.accel_x) * 32'(in_data.accel_x));
      sq_in[1] = SQ_W'(32'(in_data.accel_y) * 32'(in_data.accel_y));
      sq_in[2] = SQ_W'(32'(in_data.accel_z) * 32'(in_data.accel_z));
      sq_in[3] = SQ_W'(32'(in_data.gyro_x) * 32'(in_data.gyro_x));
      sq_in[4] = SQ_W'(32'(in_data.gyro_y) * 32'(in_data.gyro_y));
      sq_in[5] = SQ_W'(32'(in_data.gyro_z) * 32'(in_data.gyro_z));
   end

   // Each square is at most 2^30, so three of them fit in 32 bits.
   assign accel_sum = SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
   assign gyro_sum  = SUM_W'(sq_ff[3]) + SUM_W'(sq_ff[4]) + SUM_W'(sq_ff[5]);

   always_comb begin
      mag_in.panic      = sq_panic_ff;
      mag_in.rst        = sq_rst_ff;
      mag_in.accel_over = {1'b0, accel_sum} > accel_limit_sq;
      mag_in.gyro_over  = {1'b0, gyro_sum} > gyro_limit_sq;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff  <= 1'b0;
         mag_valid_ff <= 1'b0;
      end else if (advance) begin
         sq_valid_ff  <= in_valid;
         mag_valid_ff <= sq_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_ff       <= sq_in;
         sq_panic_ff <= in_data.panic_pressed;
         sq_rst_ff   <= in_data.reset_pressed;
         mag_ff      <= mag_in;
      end
   end

   assign out_valid = mag_valid_ff;
   assign out_data  = mag_ff;

endmodule
